>>> rtl/core/dsd_pkg.sv
// Shared types and constants for the detection sort and duplicate removal block.
`default_nettype none
package dsd_pkg;
   localparam int unsigned ScoreBits = 16;
   localparam int unsigned ClassBits = 7;
   localparam int unsigned CoordBits = 12;
   localparam int unsigned DimBits   = CoordBits + 1;
   localparam int unsigned RatioBits = 9;
   localparam int unsigned ReqBits   = 96;
   localparam int unsigned RspBits   = ((4*CoordBits+25+7)/8)*8;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WIDTH     = 2'd1,
      CSR_HEIGHT    = 2'd2,
      CSR_RATIO     = 2'd3
   } csr_index_type;
endpackage
`default_nettype wire

>>> rtl/core/dsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module dsd_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/core/detection_sort_and_dedup_top.sv
// Top level of the detection sort and duplicate removal block.
// Each request is one candidate; once it is accepted the block stays busy while one shared
// multiplier scales the low and high edges of x and then of y, and the candidate is then
// stored if it passes the class and score checks and the table has room (states S_X_LO,
// S_X_HI, S_Y_LO, S_Y_HI, S_WRITE). After the request marked by req_tlast the stored entries
// (at most MAX_TARGETS) are ordered by an insertion sort; a duplicate pass against a stack of
// survivors follows, and then each survivor is sent as one response, the next one being read
// only after the previous one has been taken. An empty frame gives a single response with
// entry_valid low. req_tready and csr_ready stay low from the cycle after an accepted request
// until its work is done, and for a frame's last request until its last response has been
// taken.
`default_nettype none
module detection_sort_and_dedup_top
   import dsd_pkg::*;
#(
   parameter int unsigned MAX_TARGETS = 64,
   parameter int unsigned CLASS_COUNT = 80
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // center_x, center_y, box_width, box_height, class_index, score, pad to 96 bits
   input  wire logic [ReqBits-1:0] req_tdata,
   input  wire logic               req_tlast,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // entry_valid, target_class, rect_left, rect_top, rect_width, rect_height,
   // target_score, table_overflow, then padding
   output logic [RspBits-1:0]      rsp_tdata,
   output logic                    rsp_tlast,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   localparam int unsigned AW  = $clog2(MAX_TARGETS);
   localparam int unsigned CW  = AW + 1;
   localparam int unsigned CB  = CoordBits;
   localparam int unsigned KW  = ClassBits + CB;
   localparam int unsigned PW  = 3*CB + ScoreBits;
   localparam int unsigned MW  = CB + RatioBits;
   localparam logic [DimBits-1:0] DimMax = DimBits'(1 << CB);

   typedef enum logic [4:0] {
      S_IDLE, S_X_LO, S_X_HI, S_Y_LO, S_Y_HI, S_WRITE,
      S_SORT_I, S_SORT_KEY, S_SORT_ORD, S_SORT_CMP, S_SORT_PUT,
      S_DUP_I, S_DUP_ORD, S_DUP_CUR, S_DUP_TOP, S_DUP_CMP, S_DUP_PUSH,
      S_OUT_RD, S_OUT_IDX, S_OUT_LOAD, S_OUT
   } state_type;

   state_type            state_ff;
   logic [ScoreBits-1:0] thr_ff;
   logic [DimBits-1:0]   wid_ff, hgt_ff;
   logic [RatioBits-1:0] ratio_ff;
   logic [CW-1:0]        count_ff, i_ff, j_ff, kept_ff;
   logic                 ovf_ff;
   logic [15:0]          cx_ff, cy_ff, bw_ff, bh_ff;
   logic [ScoreBits-1:0] sc_ff;
   logic [ClassBits-1:0] cls_ff;
   logic                 last_ff;
   logic [CB-1:0]        rect_l_ff, rect_t_ff, rect_w_ff, rect_h_ff;
   logic [KW-1:0]        vkey_ff, ckey_ff;
   logic [PW-1:0]        cpay_ff;
   logic [AW-1:0]        prev_ff, cidx_ff;
   logic [RspBits-1:0]   out_ff;
   logic                 oval_ff, olast_ff;

   // stores: entry keys and payloads, the sorted order and the survivor stack
   logic          tab_we, ord_we, kp_we;
   logic [AW-1:0] ent_ra, ord_wa, ord_ra, kp_wa, kp_ra;
   logic [KW-1:0] ek_wd, ek_rd;
   logic [PW-1:0] ep_wd, ep_rd;
   logic [AW-1:0] ord_wd, ord_rd, kp_wd, kp_rd;

   dsd_ram #(.Width(KW), .Depth(MAX_TARGETS)) u_keys (
      .clock, .wr_en(tab_we), .wr_addr(count_ff[AW-1:0]), .wr_data(ek_wd), .rd_addr(ent_ra),
      .rd_data(ek_rd));
   dsd_ram #(.Width(PW), .Depth(MAX_TARGETS)) u_payload (
      .clock, .wr_en(tab_we), .wr_addr(count_ff[AW-1:0]), .wr_data(ep_wd), .rd_addr(ent_ra),
      .rd_data(ep_rd));
   dsd_ram #(.Width(AW), .Depth(MAX_TARGETS)) u_order (
      .clock, .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd), .rd_addr(ord_ra),
      .rd_data(ord_rd));
   dsd_ram #(.Width(AW), .Depth(MAX_TARGETS)) u_keep (
      .clock, .wr_en(kp_we), .wr_addr(kp_wa), .wr_data(kp_wd), .rd_addr(kp_ra), .rd_data(kp_rd));

   // configuration
   assign csr_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd19661; wid_ff <= 13'd640; hgt_ff <= 13'd480; ratio_ff <= 9'd51;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: thr_ff   <= csr_data[ScoreBits-1:0];
            CSR_WIDTH:     wid_ff   <= csr_data[DimBits-1:0];
            CSR_HEIGHT:    hgt_ff   <= csr_data[DimBits-1:0];
            CSR_RATIO:     ratio_ff <= csr_data[RatioBits-1:0];
            default: ;
         endcase
      end
   end

   // Shared multiplier: one box edge of one axis times the saturated image size.
   logic               axis_y, low_edge;
   logic [DimBits-1:0] dim, nmax;
   logic [16:0]        c2;
   logic [15:0]        sz;
   logic [17:0]        diff, sum, mul_a;
   logic [30:0]        mul_p;
   logic [14:0]        quot;
   logic [CB-1:0]      edge_px;
   always_comb begin
      axis_y   = (state_ff == S_Y_LO) || (state_ff == S_Y_HI);
      low_edge = (state_ff == S_X_LO) || (state_ff == S_Y_LO);
      dim      = axis_y ? hgt_ff : wid_ff;
      if (dim == '0) dim = DimBits'(1);
      else if (dim > DimMax) dim = DimMax;
      nmax     = dim - DimBits'(1);
      c2       = {(axis_y ? cy_ff : cx_ff), 1'b0};
      sz       = axis_y ? bh_ff : bw_ff;
      diff     = {1'b0, c2} - {2'b0, sz};
      sum      = {1'b0, c2} + {2'b0, sz};
      // A low edge left of the image counts as zero.
      mul_a    = low_edge ? (diff[17] ? 18'd0 : diff) : sum;
      mul_p    = 31'(mul_a) * 31'(dim);
      quot     = mul_p[30:16];
      edge_px  = (quot > 15'(nmax)) ? nmax[CB-1:0] : quot[CB-1:0];
   end

   logic keep_cand, table_full;
   assign keep_cand  = (32'(cls_ff) < CLASS_COUNT) && (sc_ff > thr_ff);
   assign table_full = (count_ff >= CW'(MAX_TARGETS));

   // duplicate compare of current (ckey/cpay) against stack top (ek_rd/ep_rd)
   logic [CB-1:0] dl, dt;
   logic [MW-1:0] dl_s, dt_s, rw, rh;
   logic          is_dup, c_loses;
   always_comb begin
      dl   = (ckey_ff[CB-1:0] > ek_rd[CB-1:0]) ? ckey_ff[CB-1:0] - ek_rd[CB-1:0]
                                               : ek_rd[CB-1:0] - ckey_ff[CB-1:0];
      dt   = (cpay_ff[CB-1:0] > ep_rd[CB-1:0]) ? cpay_ff[CB-1:0] - ep_rd[CB-1:0]
                                               : ep_rd[CB-1:0] - cpay_ff[CB-1:0];
      dl_s = {1'b0, dl, 8'd0};
      dt_s = {1'b0, dt, 8'd0};
      rw   = MW'(ratio_ff) * MW'(cpay_ff[2*CB-1:CB]);
      rh   = MW'(ratio_ff) * MW'(cpay_ff[3*CB-1:2*CB]);
      is_dup  = (ek_rd[KW-1:CB] == ckey_ff[KW-1:CB]) && (dl_s < rw) && (dt_s < rh);
      c_loses = cpay_ff[PW-1:3*CB] < ep_rd[PW-1:3*CB];
   end

   logic [RspBits-1:0] hit_word, empty_word;
   assign hit_word   = {(RspBits-PW-KW-2)'(0), ovf_ff, ep_rd, ek_rd[CB-1:0], ek_rd[KW-1:CB],
                        1'b1};
   assign empty_word = {(RspBits-PW-KW-2)'(0), ovf_ff, (PW+KW+1)'(0)};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = oval_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = olast_ff;

   always_comb begin
      tab_we = 1'b0; ord_we = 1'b0; kp_we = 1'b0;
      ek_wd  = {cls_ff, rect_l_ff};
      ep_wd  = {sc_ff, rect_h_ff, rect_w_ff, rect_t_ff};
      ord_wa = j_ff[AW-1:0]; ord_wd = i_ff[AW-1:0]; ord_ra = '0;
      kp_wa  = kept_ff[AW-1:0]; kp_wd = cidx_ff; kp_ra = '0;
      ent_ra = '0;
      case (state_ff)
         S_WRITE: tab_we = keep_cand && !table_full;
         S_SORT_I: ent_ra = i_ff[AW-1:0];
         S_SORT_KEY: ord_ra = AW'(j_ff - CW'(1));
         S_SORT_ORD: ent_ra = ord_rd;
         S_SORT_CMP: begin
            ord_ra = AW'(j_ff - CW'(2));
            if (ek_rd > vkey_ff) begin
               ord_we = 1'b1;
               ord_wd = prev_ff;
            end
         end
         S_SORT_PUT: ord_we = 1'b1;
         S_DUP_I: ord_ra = i_ff[AW-1:0];
         S_DUP_ORD: ent_ra = ord_rd;
         S_DUP_CUR: kp_ra = AW'(kept_ff - CW'(1));
         S_DUP_TOP: ent_ra = kp_rd;
         S_DUP_CMP: kp_ra = AW'(kept_ff - CW'(2));
         S_DUP_PUSH: kp_we = 1'b1;
         S_OUT_RD: kp_ra = i_ff[AW-1:0];
         S_OUT_IDX: ent_ra = kp_rd;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ovf_ff <= 1'b0; oval_ff <= 1'b0;
         olast_ff <= 1'b0; i_ff <= '0; j_ff <= '0; kept_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               cx_ff <= req_tdata[15:0];  cy_ff <= req_tdata[31:16];
               bw_ff <= req_tdata[47:32]; bh_ff <= req_tdata[63:48];
               cls_ff <= req_tdata[70:64]; sc_ff <= req_tdata[86:71];
               last_ff <= req_tlast; state_ff <= S_X_LO;
            end
            S_X_LO: begin rect_l_ff <= edge_px; state_ff <= S_X_HI; end
            S_X_HI: begin rect_w_ff <= edge_px - rect_l_ff; state_ff <= S_Y_LO; end
            S_Y_LO: begin rect_t_ff <= edge_px; state_ff <= S_Y_HI; end
            S_Y_HI: begin rect_h_ff <= edge_px - rect_t_ff; state_ff <= S_WRITE; end
            S_WRITE: begin
               if (keep_cand) begin
                  if (!table_full) count_ff <= count_ff + CW'(1);
                  else ovf_ff <= 1'b1;
               end
               if (last_ff) begin i_ff <= '0; state_ff <= S_SORT_I; end
               else state_ff <= S_IDLE;
            end
            S_SORT_I: begin
               if (i_ff == count_ff) begin
                  i_ff <= '0; kept_ff <= '0; state_ff <= S_DUP_I;
               end else begin
                  j_ff <= i_ff; state_ff <= S_SORT_KEY;
               end
            end
            S_SORT_KEY: begin
               vkey_ff  <= ek_rd;
               state_ff <= (j_ff == '0) ? S_SORT_PUT : S_SORT_ORD;
            end
            S_SORT_ORD: begin prev_ff <= ord_rd; state_ff <= S_SORT_CMP; end
            S_SORT_CMP: begin
               // A strictly greater key moves up one place, so equal keys keep arrival order.
               if (ek_rd > vkey_ff) begin
                  j_ff     <= j_ff - CW'(1);
                  state_ff <= (j_ff == CW'(1)) ? S_SORT_PUT : S_SORT_ORD;
               end else state_ff <= S_SORT_PUT;
            end
            S_SORT_PUT: begin i_ff <= i_ff + CW'(1); state_ff <= S_SORT_I; end
            S_DUP_I: begin
               if (i_ff != count_ff) state_ff <= S_DUP_ORD;
               else if (kept_ff == '0) begin
                  out_ff <= empty_word; oval_ff <= 1'b1; olast_ff <= 1'b1; state_ff <= S_OUT;
               end else begin
                  i_ff <= '0; state_ff <= S_OUT_RD;
               end
            end
            S_DUP_ORD: begin cidx_ff <= ord_rd; state_ff <= S_DUP_CUR; end
            S_DUP_CUR: begin
               ckey_ff  <= ek_rd; cpay_ff <= ep_rd;
               state_ff <= (kept_ff == '0) ? S_DUP_PUSH : S_DUP_TOP;
            end
            S_DUP_TOP: state_ff <= S_DUP_CMP;
            S_DUP_CMP: begin
               if (!is_dup) state_ff <= S_DUP_PUSH;
               else if (c_loses) begin
                  i_ff <= i_ff + CW'(1); state_ff <= S_DUP_I;
               end else begin
                  // The earlier entry loses on a tie; check the next survivor back.
                  kept_ff  <= kept_ff - CW'(1);
                  state_ff <= (kept_ff == CW'(1)) ? S_DUP_PUSH : S_DUP_TOP;
               end
            end
            S_DUP_PUSH: begin
               kept_ff <= kept_ff + CW'(1); i_ff <= i_ff + CW'(1); state_ff <= S_DUP_I;
            end
            S_OUT_RD: state_ff <= S_OUT_IDX;
            S_OUT_IDX: state_ff <= S_OUT_LOAD;
            S_OUT_LOAD: begin
               out_ff   <= hit_word; oval_ff <= 1'b1;
               olast_ff <= (i_ff + CW'(1) == kept_ff);
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) begin
               oval_ff <= 1'b0;
               if (olast_ff) begin
                  count_ff <= '0; ovf_ff <= 1'b0; state_ff <= S_IDLE;
               end else begin
                  i_ff <= i_ff + CW'(1); state_ff <= S_OUT_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast));
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_TARGETS));
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid));
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> state_ff == S_OUT);
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the detection sort and duplicate removal block.
module testbench
   import dsd_pkg::*;
();

   typedef struct {
      bit        present;
      bit [6:0]  cls;
      bit [11:0] left, top, wid, hgt;
      bit [15:0] score;
      bit        final_one;
      bit        dropped;
   } detection_type;

   // Tracks the block's table and configuration and holds the detections it should emit.
   class scoreboard_type;
      bit [15:0] threshold = 16'd19661;
      bit [12:0] img_w = 13'd640, img_h = 13'd480;
      bit [8:0]  ratio = 9'd51;
      bit [18:0] keys[64];
      bit [11:0] tops[64], wids[64], hgts[64];
      bit [15:0] scores[64];
      int        count;
      bit        overflow;
      detection_type pending_q[$];
      int        errors;

      function void write_reg(csr_index_type idx, bit [31:0] v);
         case (idx)
            CSR_THRESHOLD: threshold = v[15:0];
            CSR_WIDTH:     img_w = v[12:0];
            CSR_HEIGHT:    img_h = v[12:0];
            CSR_RATIO:     ratio = v[8:0];
            default: ;
         endcase
      endfunction

      function int unsigned sat_dim(bit [12:0] v);
         if (v == 0) return 1;
         if (v > 4096) return 4096;
         return v;
      endfunction

      function void clamp_axis(input bit [15:0] c, input bit [15:0] s, input int unsigned n,
                               output bit [11:0] lo, output bit [11:0] len);
         longint a, b, l, r;
         a = (2 * longint'(c) - longint'(s)) * longint'(n);
         b = (2 * longint'(c) + longint'(s)) * longint'(n);
         l = (a < 0) ? 0 : (a >>> 16);
         if (l > n - 1) l = n - 1;
         r = b >>> 16;
         if (r > n - 1) r = n - 1;
         lo  = l[11:0];
         len = 12'(r - l);
      endfunction

      function bit is_duplicate(int p, int c);
         int unsigned dx, dy;
         if (keys[p][18:12] != keys[c][18:12]) return 0;
         dx = (keys[c][11:0] > keys[p][11:0]) ? keys[c][11:0] - keys[p][11:0]
                                              : keys[p][11:0] - keys[c][11:0];
         dy = (tops[c] > tops[p]) ? tops[c] - tops[p] : tops[p] - tops[c];
         return (dx * 256 < ratio * wids[c]) && (dy * 256 < ratio * hgts[c]);
      endfunction

      function void note_request(bit [15:0] cx, bit [15:0] cy, bit [15:0] bw, bit [15:0] bh,
                                 bit [6:0] cls, bit [15:0] sc, bit last_one);
         bit [11:0] l, w, t, h;
         int order[64];
         int survivors[$];
         int j, v;
         bit lost;
         detection_type d;
         if (cls < 80 && sc > threshold) begin
            if (count >= 64) overflow = 1;
            else begin
               clamp_axis(cx, bw, sat_dim(img_w), l, w);
               clamp_axis(cy, bh, sat_dim(img_h), t, h);
               keys[count] = {cls, l};
               tops[count] = t; wids[count] = w; hgts[count] = h; scores[count] = sc;
               count++;
            end
         end
         if (!last_one) return;
         // Stable insertion sort on class then left edge.
         for (int i = 0; i < count; i++) begin
            j = i;
            while (j > 0 && keys[order[j-1]] > keys[i]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
         end
         for (int i = 0; i < count; i++) begin
            v = order[i];
            lost = 0;
            while (survivors.size() > 0 && is_duplicate(survivors[$], v)) begin
               if (scores[v] < scores[survivors[$]]) begin
                  lost = 1;
                  break;
               end
               void'(survivors.pop_back());
            end
            if (!lost) survivors = {survivors, v};
         end
         if (survivors.size() == 0) begin
            d = '{default: 0};
            d.final_one = 1;
            d.dropped = overflow;
            pending_q = {pending_q, d};
         end
         foreach (survivors[i]) begin
            v = survivors[i];
            d.present = 1;
            d.cls = keys[v][18:12];
            d.left = keys[v][11:0];
            d.top = tops[v]; d.wid = wids[v]; d.hgt = hgts[v];
            d.score = scores[v];
            d.final_one = (i == survivors.size() - 1);
            d.dropped = overflow;
            pending_q = {pending_q, d};
         end
         count = 0;
         overflow = 0;
      endfunction

      function void compare_field(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(detection_type a);
         detection_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected detection, expected none, got class %0d left %0d",
                     $time, a.cls, a.left);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         compare_field("entry_valid", e.present, a.present);
         compare_field("target_class", e.cls, a.cls);
         compare_field("rect_left", e.left, a.left);
         compare_field("rect_top", e.top, a.top);
         compare_field("rect_width", e.wid, a.wid);
         compare_field("rect_height", e.hgt, a.hgt);
         compare_field("target_score", e.score, a.score);
         compare_field("last_result", e.final_one, a.final_one);
         compare_field("table_overflow", e.dropped, a.dropped);
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tlast = 0;
   logic [95:0] req_tdata = '0;
   logic        req_tready;
   logic        rsp_tvalid, rsp_tlast;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   scoreboard_type model = new();
   bit quiet;
   int hold_off;

   detection_sort_and_dedup_top dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #30_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: checks every accepted detection and stalls at random.
   initial begin
      detection_type a;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            a.present = rsp_tdata[0];
            a.cls = rsp_tdata[7:1];
            a.left = rsp_tdata[19:8];
            a.top = rsp_tdata[31:20];
            a.wid = rsp_tdata[43:32];
            a.hgt = rsp_tdata[55:44];
            a.score = rsp_tdata[71:56];
            a.dropped = rsp_tdata[72];
            a.final_one = rsp_tlast;
            model.check_result(a);
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 0;
         end else rsp_tready <= quiet || ($urandom_range(99) >= 8);
      end
   end

   task automatic send_request(bit [15:0] cx, bit [15:0] cy, bit [15:0] bw, bit [15:0] bh,
                               bit [6:0] cls, bit [15:0] sc, bit last_one);
      while (!quiet && $urandom_range(99) < 8) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {9'b0, sc, cls, bh, bw, cy, cx};
      req_tlast <= last_one;
      do @(posedge clock); while (!req_tready);
      model.note_request(cx, cy, bw, bh, cls, sc, last_one);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (model.pending_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      model.write_reg(idx, v);
      csr_valid <= 0;
   endtask

   // A frame of candidates, mostly clustered around a few centres so that duplicates occur.
   task automatic send_frame(int n);
      bit [15:0] bx, by, bw, bh, sc;
      bit [6:0] cls;
      int mode;
      bx = 16'($urandom_range(2000, 62000)); by = 16'($urandom_range(2000, 62000));
      bw = 16'($urandom_range(500, 20000));  bh = 16'($urandom_range(500, 20000));
      cls = 7'($urandom_range(3));
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(99);
         if (mode < 15) begin
            send_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         7'($urandom), 16'($urandom), i == n-1);
         end else begin
            if (mode < 35) begin
               bx = 16'($urandom_range(2000, 62000)); by = 16'($urandom_range(2000, 62000));
               cls = (mode < 20) ? 7'($urandom_range(79)) : 7'($urandom_range(3));
            end
            sc = ($urandom_range(3) == 0) ? 16'd40000 : 16'($urandom_range(15000, 65535));
            send_request(16'(bx + $urandom_range(300)), 16'(by + $urandom_range(300)),
                         16'(bw + $urandom_range(600)), 16'(bh + $urandom_range(600)),
                         cls, sc, i == n-1);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: clamping at both edges, class limits, score at the threshold, ties.
      send_request(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 7'd0, 16'hFFFF, 0);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd79, 16'd19662, 0);
      send_request(16'd16384, 16'd16384, 16'd0, 16'd0, 7'd80, 16'hFFFF, 0);
      send_request(16'd16384, 16'd16384, 16'd4000, 16'd4000, 7'd127, 16'hFFFF, 0);
      send_request(16'd16384, 16'd16384, 16'd4000, 16'd4000, 7'd5, 16'd19661, 0);
      send_request(16'd16384, 16'd16384, 16'd4000, 16'd4000, 7'd5, 16'd30000, 0);
      send_request(16'd16400, 16'd16400, 16'd4000, 16'd4000, 7'd5, 16'd30000, 0);
      send_request(16'd16450, 16'd16380, 16'd4000, 16'd4000, 7'd5, 16'd20000, 1);
      // Empty frame: nothing above the threshold.
      send_request(16'd100, 16'd100, 16'd100, 16'd100, 7'd1, 16'd0, 1);
      wait_idle();

      write_reg(CSR_THRESHOLD, 32'd0);
      write_reg(CSR_WIDTH, 32'd0);
      write_reg(CSR_HEIGHT, 32'd8191);
      write_reg(CSR_RATIO, 32'd256);
      send_request(16'd0, 16'd65535, 16'd65535, 16'd0, 7'd2, 16'd1, 0);
      send_request(16'd0, 16'd65535, 16'd65535, 16'd0, 7'd2, 16'd0, 1);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_reg(CSR_THRESHOLD, 32'd30000);
               write_reg(CSR_WIDTH, 32'd4096);
               write_reg(CSR_HEIGHT, 32'd4096);
               write_reg(CSR_RATIO, 32'd0);
            end
            2: begin
               write_reg(CSR_THRESHOLD, 32'd1000);
               write_reg(CSR_WIDTH, 32'd1);
               write_reg(CSR_HEIGHT, 32'd1);
               write_reg(CSR_RATIO, 32'd256);
            end
            3: begin
               write_reg(CSR_THRESHOLD, 32'hFFFF);
               write_reg(CSR_WIDTH, 32'd8191);
               write_reg(CSR_HEIGHT, 32'd0);
            end
            default: begin
               write_reg(CSR_THRESHOLD, $urandom_range(25000));
               write_reg(CSR_WIDTH, $urandom_range(1, 4096));
               write_reg(CSR_HEIGHT, $urandom_range(1, 4096));
               write_reg(CSR_RATIO, $urandom_range(256));
            end
         endcase
         for (int k = 0; k < 9; k++) begin
            quiet = (phase == 4);
            if (phase == 1 && k == 2) hold_off = 400;
            send_frame($urandom_range(1, 12));
         end
         // A frame larger than the table, so that candidates are dropped.
         if (phase == 0 || phase == 5) begin
            wait_idle();
            write_reg(CSR_THRESHOLD, 32'd0);
            for (int i = 0; i < 68; i++)
               send_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            7'($urandom_range(79)), 16'($urandom_range(1, 65535)), i == 67);
         end
         quiet = 0;
         wait_idle();
      end

      if (model.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
